// File: rtl/core/polygon_convexity_check_unit_assert.svh
// ----------------------------------------------------------------------------
// polygon convexity check assertion macros
// Concurrent checks on clk, disabled while rst is high; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef POLYGON_CONVEXITY_CHECK_UNIT_ASSERT_SVH
`define POLYGON_CONVEXITY_CHECK_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define PCC_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcc assertion failed");
// next-cycle implication
`define PCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcc assertion failed");
`else
`define PCC_ASSERT_IMPLIES(lbl, ante, cons)
`define PCC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/core/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants of the polygon convexity check unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

  localparam int EPS_WIDTH    = 33;
  localparam int STATUS_WIDTH = 2;

  // vertex slots carried with each job; triple k uses slots k, k+1, k+2
  localparam int NUM_VERTS   = 5;
  localparam int NUM_TRIPLES = 3;
  localparam int V_OLDER     = 0;
  localparam int V_NEWER     = 1;
  localparam int V_CURRENT   = 2;
  localparam int V_FIRST     = 3;
  localparam int V_SECOND    = 4;

  localparam logic [STATUS_WIDTH-1:0] STATUS_CONVEX     = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] STATUS_NOT_CONVEX = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] STATUS_TOO_FEW    = 2'd2;

  typedef struct packed {
    logic run_main;  // triple older, newer, current
    logic run_wrap;  // both wrap triples, last vertex of a polygon of three or more
    logic last;
  } job_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/pcc_fifo.sv
// ----------------------------------------------------------------------------
// pcc_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pcc_front.sv
// ----------------------------------------------------------------------------
// pcc_front
// Tracks the vertex history of the current polygon and builds one job per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_front #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    accept,
  input  wire logic [COORD_WIDTH-1:0]  vertex_x,
  input  wire logic [COORD_WIDTH-1:0]  vertex_y,
  input  wire logic                    last_vertex,
  output pcc_pkg::job_ctl_t            job_ctl,
  output logic [pcc_pkg::NUM_VERTS-1:0][COORD_WIDTH-1:0] job_x,
  output logic [pcc_pkg::NUM_VERTS-1:0][COORD_WIDTH-1:0] job_y
);

  logic [1:0]             seen_count;
  logic [COORD_WIDTH-1:0] first_x;
  logic [COORD_WIDTH-1:0] first_y;
  logic [COORD_WIDTH-1:0] second_x;
  logic [COORD_WIDTH-1:0] second_y;
  logic [COORD_WIDTH-1:0] older_x;
  logic [COORD_WIDTH-1:0] older_y;
  logic [COORD_WIDTH-1:0] newer_x;
  logic [COORD_WIDTH-1:0] newer_y;
  logic [1:0]             seen_count_next;

  // two or more vertices already seen means a full triple is available
  assign job_ctl.run_main = seen_count[1];
  assign job_ctl.run_wrap = seen_count[1] && last_vertex;
  assign job_ctl.last     = last_vertex;

  always_comb begin
    job_x = '0;
    job_y = '0;
    job_x[pcc_pkg::V_OLDER]   = older_x;
    job_y[pcc_pkg::V_OLDER]   = older_y;
    job_x[pcc_pkg::V_NEWER]   = newer_x;
    job_y[pcc_pkg::V_NEWER]   = newer_y;
    job_x[pcc_pkg::V_CURRENT] = vertex_x;
    job_y[pcc_pkg::V_CURRENT] = vertex_y;
    job_x[pcc_pkg::V_FIRST]   = first_x;
    job_y[pcc_pkg::V_FIRST]   = first_y;
    job_x[pcc_pkg::V_SECOND]  = second_x;
    job_y[pcc_pkg::V_SECOND]  = second_y;
  end

  always_comb begin
    if (last_vertex) begin
      seen_count_next = '0;
    end else if (seen_count == 2'd3) begin
      seen_count_next = seen_count;
    end else begin
      seen_count_next = seen_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= '0;
    end else if (accept) begin
      seen_count <= seen_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (seen_count == 2'd0) begin
        first_x <= vertex_x;
        first_y <= vertex_y;
      end
      if (seen_count == 2'd1) begin
        second_x <= vertex_x;
        second_y <= vertex_y;
      end
      older_x <= newer_x;
      older_y <= newer_y;
      newer_x <= vertex_x;
      newer_y <= vertex_y;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pcc_back.sv
// ----------------------------------------------------------------------------
// pcc_back
// Forms up to three cross products per job, applies the dead band, keeps the
// sign marks and issues the polygon status.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polygon_convexity_check_unit_assert.svh"

module pcc_back #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                epsilon_we,
  input  wire logic [pcc_pkg::EPS_WIDTH-1:0]       epsilon_wdata,
  input  wire logic                                job_valid,
  input  wire pcc_pkg::job_ctl_t                   job_ctl,
  input  wire logic [pcc_pkg::NUM_VERTS-1:0][COORD_WIDTH-1:0] job_x,
  input  wire logic [pcc_pkg::NUM_VERTS-1:0][COORD_WIDTH-1:0] job_y,
  output logic                                     job_pop,
  input  wire logic                                res_full,
  output logic                                     res_push,
  output logic [pcc_pkg::STATUS_WIDTH-1:0]         res_status
);

  localparam int NT   = pcc_pkg::NUM_TRIPLES;
  localparam int DW   = COORD_WIDTH + 1;
  localparam int PW   = 2 * DW;
  localparam int ZW   = PW + 1;
  localparam int CMPW = (ZW > pcc_pkg::EPS_WIDTH + 1) ? ZW : pcc_pkg::EPS_WIDTH + 1;

  logic [pcc_pkg::EPS_WIDTH-1:0] epsilon_q;
  logic                          s1_valid;
  pcc_pkg::job_ctl_t             s1_ctl;
  logic signed [PW-1:0]          s1_p [NT];
  logic signed [PW-1:0]          s1_q [NT];
  logic signed [PW-1:0]          prod_p [NT];
  logic signed [PW-1:0]          prod_q [NT];
  logic [NT-1:0]                 en;
  logic [NT-1:0]                 hit_pos;
  logic [NT-1:0]                 hit_neg;
  logic signed [CMPW-1:0]        eps_pos;
  logic signed [CMPW-1:0]        eps_neg;
  logic                          pos_seen;
  logic                          neg_seen;
  logic                          pos_next;
  logic                          neg_next;
  logic                          retire;
  logic                          advance;

  // stage 0: edge differences and products straight off the queue head
  for (genvar k = 0; k < NT; k++) begin : g_mul
    logic signed [DW-1:0] ax, ay, bx, by, cx, cy;
    logic signed [DW-1:0] x1, y1, x2, y2;
    assign ax = DW'(signed'(job_x[k]));
    assign ay = DW'(signed'(job_y[k]));
    assign bx = DW'(signed'(job_x[k+1]));
    assign by = DW'(signed'(job_y[k+1]));
    assign cx = DW'(signed'(job_x[k+2]));
    assign cy = DW'(signed'(job_y[k+2]));
    assign x1 = bx - ax;
    assign y1 = by - ay;
    assign x2 = cx - bx;
    assign y2 = cy - by;
    assign prod_p[k] = PW'(x1) * PW'(y2);
    assign prod_q[k] = PW'(y1) * PW'(x2);
  end

  // stage 1: z = p - q against the dead band
  assign eps_pos = signed'(CMPW'(epsilon_q));
  assign eps_neg = -eps_pos;
  assign en      = {s1_ctl.run_wrap, s1_ctl.run_wrap, s1_ctl.run_main};

  for (genvar k = 0; k < NT; k++) begin : g_cmp
    logic signed [ZW-1:0]   z;
    logic signed [CMPW-1:0] z_ext;
    assign z          = ZW'(s1_p[k]) - ZW'(s1_q[k]);
    assign z_ext      = CMPW'(z);
    assign hit_pos[k] = en[k] && (z_ext > eps_pos);
    assign hit_neg[k] = en[k] && (z_ext < eps_neg);
  end

  assign pos_next = pos_seen || (|hit_pos);
  assign neg_next = neg_seen || (|hit_neg);

  always_comb begin
    if (!s1_ctl.run_wrap) begin
      res_status = pcc_pkg::STATUS_TOO_FEW;
    end else if (pos_next && neg_next) begin
      res_status = pcc_pkg::STATUS_NOT_CONVEX;
    end else begin
      res_status = pcc_pkg::STATUS_CONVEX;
    end
  end

  // only a final beat needs room in the result queue
  assign retire   = s1_valid && !(s1_ctl.last && res_full);
  assign advance  = !s1_valid || retire;
  assign job_pop  = job_valid && advance;
  assign res_push = retire && s1_ctl.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon_q <= '0;
      s1_valid  <= 1'b0;
      pos_seen  <= 1'b0;
      neg_seen  <= 1'b0;
    end else begin
      if (epsilon_we) begin
        epsilon_q <= epsilon_wdata;
      end
      if (advance) begin
        s1_valid <= job_valid;
      end
      if (retire) begin
        pos_seen <= s1_ctl.last ? 1'b0 : pos_next;
        neg_seen <= s1_ctl.last ? 1'b0 : neg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ctl <= job_ctl;
      for (int k = 0; k < NT; k++) begin
        s1_p[k] <= prod_p[k];
        s1_q[k] <= prod_q[k];
      end
    end
  end

  `PCC_ASSERT_NEXT(a_hold_stalled, s1_valid && !retire, s1_valid && $stable(s1_ctl))
  `PCC_ASSERT_NEXT(a_marks_clear, retire && s1_ctl.last, !pos_seen && !neg_seen)
  `PCC_ASSERT_IMPLIES(a_wrap_on_last, s1_valid && s1_ctl.run_wrap, s1_ctl.last)
  `PCC_ASSERT_IMPLIES(a_status_code, res_push, res_status == pcc_pkg::STATUS_CONVEX || res_status == pcc_pkg::STATUS_NOT_CONVEX || res_status == pcc_pkg::STATUS_TOO_FEW)

endmodule

`default_nettype wire

// File: rtl/core/polygon_convexity_check_unit.sv
// ----------------------------------------------------------------------------
// polygon_convexity_check_unit
// Convexity test of a vertex stream by the signs of edge cross products.
// ----------------------------------------------------------------------------
// throughput: one vertex per cycle while the job queue is not full; the three
//   cross products of a last vertex run side by side in the back end
// path: a last vertex passes the job queue, the stage 1 register and the result queue
// reset: rst clears the queues, vertex count, sign marks and epsilon (to 0)
`default_nettype none

module polygon_convexity_check_unit #(
  parameter int COORD_WIDTH = 16,
  parameter int JOB_DEPTH   = 4,
  parameter int RES_DEPTH   = 2
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               epsilon_we,
  input  wire logic [pcc_pkg::EPS_WIDTH-1:0]      epsilon,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic signed [COORD_WIDTH-1:0]      vertex_x,
  input  wire logic signed [COORD_WIDTH-1:0]      vertex_y,
  input  wire logic                               last_vertex,
  input  wire logic                               pop,
  output logic                                    empty,
  output logic [pcc_pkg::STATUS_WIDTH-1:0]        status
);

  localparam int CTL_W = $bits(pcc_pkg::job_ctl_t);
  localparam int VEC_W = pcc_pkg::NUM_VERTS * COORD_WIDTH;
  localparam int JOB_W = CTL_W + 2 * VEC_W;

  pcc_pkg::job_ctl_t                                front_ctl;
  logic [pcc_pkg::NUM_VERTS-1:0][COORD_WIDTH-1:0]   front_x;
  logic [pcc_pkg::NUM_VERTS-1:0][COORD_WIDTH-1:0]   front_y;
  logic [JOB_W-1:0]                                 job_wdata;
  logic [JOB_W-1:0]                                 job_rdata;
  logic                                             job_empty;
  logic                                             job_pop;
  pcc_pkg::job_ctl_t                                back_ctl;
  logic [pcc_pkg::NUM_VERTS-1:0][COORD_WIDTH-1:0]   back_x;
  logic [pcc_pkg::NUM_VERTS-1:0][COORD_WIDTH-1:0]   back_y;
  logic                                             res_full;
  logic                                             res_push;
  logic [pcc_pkg::STATUS_WIDTH-1:0]                 res_status;
  logic                                             accept;

  assign accept = push && !full;

  pcc_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .last_vertex (last_vertex),
    .job_ctl     (front_ctl),
    .job_x       (front_x),
    .job_y       (front_y)
  );

  assign job_wdata = {front_ctl, front_x, front_y};

  pcc_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (job_wdata),
    .full  (full),
    .pop   (job_pop),
    .rdata (job_rdata),
    .empty (job_empty)
  );

  assign {back_ctl, back_x, back_y} = job_rdata;

  pcc_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .epsilon_we    (epsilon_we),
    .epsilon_wdata (epsilon),
    .job_valid     (!job_empty),
    .job_ctl       (back_ctl),
    .job_x         (back_x),
    .job_y         (back_y),
    .job_pop       (job_pop),
    .res_full      (res_full),
    .res_push      (res_push),
    .res_status    (res_status)
  );

  pcc_fifo #(
    .WIDTH (pcc_pkg::STATUS_WIDTH),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_status),
    .full  (res_full),
    .pop   (pop),
    .rdata (status),
    .empty (empty)
  );

endmodule

`default_nettype wire
